// ----- hw/rtl/sgtr_pkg.sv -----
// Package: shared types, constants and font table for the glyph text renderer.
package sgtr_pkg;

  localparam int FrameWidth  = 400;
  localparam int FrameHeight = 300;
  localparam int RowBytes    = FrameWidth / 8;
  localparam int StoreBytes  = RowBytes * FrameHeight;
  localparam int AddrW       = $clog2(StoreBytes);

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_DRAW  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        command;
    logic [7:0]  char_code;
    logic [7:0]  char_index;
    logic signed [11:0] x_pos;
    logic signed [11:0] y_pos;
    logic [3:0]  scale;
    logic [13:0] read_address;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_PIXEL,
    ST_RMW,
    ST_READ,
    ST_READ_WAIT,
    ST_DONE
  } state_t;

  function automatic logic [7:0] glyph_col(input logic [7:0] code, input logic [2:0] col);
    logic [39:0] g;
    g = 40'h0;
    case (code)
      8'h41: g = 40'h7E1111117E; 8'h42: g = 40'h7F49494936;
      8'h43: g = 40'h3E41414122; 8'h44: g = 40'h7F4141221C;
      8'h45: g = 40'h7F49494941; 8'h46: g = 40'h7F09090901;
      8'h47: g = 40'h3E4149493A; 8'h48: g = 40'h7F0808087F;
      8'h49: g = 40'h00417F4100; 8'h4B: g = 40'h7F08142241;
      8'h4C: g = 40'h7F40404040; 8'h4D: g = 40'h7F020C027F;
      8'h4E: g = 40'h7F0408107F; 8'h4F: g = 40'h3E4141413E;
      8'h50: g = 40'h7F09090906; 8'h52: g = 40'h7F09192946;
      8'h53: g = 40'h2649494932; 8'h54: g = 40'h01017F0101;
      8'h55: g = 40'h3F4040403F; 8'h56: g = 40'h1F2040201F;
      8'h57: g = 40'h3F4038403F; 8'h58: g = 40'h6314081463;
      8'h59: g = 40'h0708700807; 8'h5A: g = 40'h6151494543;
      8'h61: g = 40'h2054545478; 8'h62: g = 40'h7F48444438;
      8'h63: g = 40'h3844444428; 8'h64: g = 40'h384444287F;
      8'h65: g = 40'h3854545418; 8'h66: g = 40'h00087E0902;
      8'h67: g = 40'h18A4A4A47C; 8'h68: g = 40'h7F08040478;
      8'h69: g = 40'h00447D4000; 8'h6B: g = 40'h7F10284400;
      8'h6C: g = 40'h00417F4000; 8'h6D: g = 40'h7C04180478;
      8'h6E: g = 40'h7C08040478; 8'h6F: g = 40'h3844444438;
      8'h70: g = 40'h7C14141408; 8'h72: g = 40'h7C08040408;
      8'h73: g = 40'h4854545424; 8'h74: g = 40'h043F444020;
      8'h75: g = 40'h3C4040207C; 8'h76: g = 40'h1C2040201C;
      8'h77: g = 40'h3C4030403C;
      8'h30: g = 40'h3E5149453E; 8'h31: g = 40'h00427F4000;
      8'h32: g = 40'h4261514946; 8'h33: g = 40'h2141454B31;
      8'h34: g = 40'h1814127F10; 8'h35: g = 40'h2745454539;
      8'h36: g = 40'h3C4A494930; 8'h37: g = 40'h0171090503;
      8'h38: g = 40'h3649494936; 8'h39: g = 40'h064949291E;
      8'h3A: g = 40'h0000363600; 8'h2D: g = 40'h0808080808;
      8'h2E: g = 40'h0060600000; 8'h2F: g = 40'h2010080402;
      8'h21: g = 40'h00005F0000;
      default: g = 40'h0;
    endcase
    case (col)
      3'd0: glyph_col = g[39:32];
      3'd1: glyph_col = g[31:24];
      3'd2: glyph_col = g[23:16];
      3'd3: glyph_col = g[15:8];
      default: glyph_col = g[7:0];
    endcase
  endfunction

endpackage

// ----- hw/rtl/sgtr_front.sv -----
// Front end: accepts commands into a short queue ahead of the renderer.
module sgtr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  output logic                ready,
  input  sgtr_pkg::item_t     in_item,
  output logic                q_valid,
  input  logic                q_ready,
  output sgtr_pkg::item_t     q_item
);

  sgtr_pkg::item_t slots [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;

  assign ready   = (count != 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (valid && ready) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (valid && ready) wr_ptr <= ~wr_ptr;
      if (q_valid && q_ready) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, valid && ready} - {1'b0, q_valid && q_ready};
    end
  end

endmodule

// ----- hw/rtl/sgtr_back.sv -----
// Back end: clears, draws and reads the frame store, one command at a time.
module sgtr_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  sgtr_pkg::item_t     q_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          read_data
);

  localparam int AW = sgtr_pkg::AddrW;

  logic [7:0] mem [sgtr_pkg::StoreBytes];
  logic [7:0] rd_q;

  sgtr_pkg::state_t state, state_next;
  sgtr_pkg::item_t  cur;

  // Clearing pass runs after reset and on a clear command.
  logic [AW-1:0] clr_addr;
  logic        boot_sweep;
  logic [2:0]  col;
  logic [2:0]  row;
  logic [3:0]  dx, dy;
  logic signed [24:0] cx;
  logic signed [24:0] px, py;
  logic [AW-1:0] pix_addr;
  logic [2:0]  pix_bit;
  logic        pix_ok;
  logic [7:0]  colbits;
  logic        last_clr, last_blk, last_pix;
  logic [7:0]  result;

  assign colbits = sgtr_pkg::glyph_col(cur.char_code, col);

  always_comb begin
    logic signed [24:0] pyw;
    logic [24:0] idx;
    px = cx + $signed(25'(col) * 25'(cur.scale)) + $signed(25'(dx));
    pyw = 25'(cur.y_pos) + $signed(25'(row) * 25'(cur.scale)) + $signed(25'(dy));
    py = pyw;
    pix_ok = (px >= 0) && (px < sgtr_pkg::FrameWidth) && (py >= 0) &&
             (py < sgtr_pkg::FrameHeight);
    idx = 25'(py[11:0]) * 25'(sgtr_pkg::RowBytes) + 25'(px[11:3]);
    if (idx >= 25'(sgtr_pkg::StoreBytes)) pix_ok = 1'b0;
    pix_addr = idx[AW-1:0];
    pix_bit = px[2:0];
  end

  assign last_clr = (clr_addr == AW'(sgtr_pkg::StoreBytes - 1));
  assign last_blk = (dx == cur.scale - 4'd1) && (dy == cur.scale - 4'd1);
  assign last_pix = (col == 3'd4) && (row == 3'd6);

  always_comb begin
    state_next = state;
    case (state)
      sgtr_pkg::ST_IDLE:
        if (q_valid) begin
          case (q_item.command)
            sgtr_pkg::CMD_CLEAR: state_next = sgtr_pkg::ST_CLEAR;
            sgtr_pkg::CMD_DRAW:
              state_next = (q_item.scale == 4'd0) ? sgtr_pkg::ST_DONE : sgtr_pkg::ST_PIXEL;
            sgtr_pkg::CMD_READ:  state_next = sgtr_pkg::ST_READ;
            default:             state_next = sgtr_pkg::ST_DONE;
          endcase
        end
      // The sweep after reset answers no command, so it returns straight to idle.
      sgtr_pkg::ST_CLEAR:
        if (last_clr) state_next = boot_sweep ? sgtr_pkg::ST_IDLE : sgtr_pkg::ST_DONE;
      sgtr_pkg::ST_PIXEL:
        if (colbits[row] && pix_ok) state_next = sgtr_pkg::ST_RMW;
        else if (!colbits[row] || last_blk) begin
          if (last_pix) state_next = sgtr_pkg::ST_DONE;
        end
      sgtr_pkg::ST_RMW:
        if (last_blk && last_pix) state_next = sgtr_pkg::ST_DONE;
        else state_next = sgtr_pkg::ST_PIXEL;
      sgtr_pkg::ST_READ:      state_next = sgtr_pkg::ST_READ_WAIT;
      sgtr_pkg::ST_READ_WAIT: state_next = sgtr_pkg::ST_DONE;
      sgtr_pkg::ST_DONE:      if (out_ready) state_next = sgtr_pkg::ST_IDLE;
      default:                state_next = sgtr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready   = (state == sgtr_pkg::ST_IDLE);
    out_valid = (state == sgtr_pkg::ST_DONE);
    read_data = result;
  end

  // Step the block, then the glyph bit; after a write the next pixel proceeds.
  logic step;
  assign step = (state == sgtr_pkg::ST_RMW) ||
                (state == sgtr_pkg::ST_PIXEL && !(colbits[row] && pix_ok));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sgtr_pkg::ST_CLEAR;
      clr_addr   <= '0;
      boot_sweep <= 1'b1;
      result     <= 8'd0;
    end else begin
      state <= state_next;
      if (state == sgtr_pkg::ST_CLEAR) clr_addr <= last_clr ? '0 : clr_addr + 1'b1;
      if (state == sgtr_pkg::ST_CLEAR && last_clr) boot_sweep <= 1'b0;
      if (state == sgtr_pkg::ST_IDLE && q_valid) result <= 8'd0;
      if (state == sgtr_pkg::ST_READ_WAIT && cur.read_address < 14'(sgtr_pkg::StoreBytes))
        result <= rd_q;
    end
  end

  always_ff @(posedge clk) begin
    if (state == sgtr_pkg::ST_IDLE && q_valid) begin
      cur <= q_item;
      cx  <= 25'(q_item.x_pos) +
             $signed(25'(q_item.char_index) * 25'(q_item.scale) * 25'd6);
      col <= 3'd0;
      row <= 3'd0;
      dx  <= 4'd0;
      dy  <= 4'd0;
    end else if (step) begin
      if (!colbits[row] || last_blk) begin
        dx <= 4'd0;
        dy <= 4'd0;
        if (row == 3'd6) begin
          row <= 3'd0;
          col <= col + 3'd1;
        end else begin
          row <= row + 3'd1;
        end
      end else if (dx == cur.scale - 4'd1) begin
        dx <= 4'd0;
        dy <= dy + 4'd1;
      end else begin
        dx <= dx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == sgtr_pkg::ST_CLEAR) mem[clr_addr] <= 8'hFF;
    else if (state == sgtr_pkg::ST_RMW) mem[pix_addr] <= rd_q & ~(8'h80 >> pix_bit);
    rd_q <= mem[(state == sgtr_pkg::ST_READ) ? cur.read_address[AW-1:0] : pix_addr];
  end

endmodule

// ----- hw/rtl/scaled_glyph_text_renderer_top.sv -----
// Top level of the scaled glyph text renderer.
// Commands pass a two-entry queue to a renderer that owns the 15000-byte frame store, and
// each command returns one result in command order. After reset and on every clear the
// store is swept one byte a cycle; the renderer takes no command from the queue during the
// sweep, and the sweep after reset returns no result. A read passes the READ and READ_WAIT
// states before its result is offered. A draw steps through every clear glyph bit, through
// each scaled pixel that is clipped, and through a read and then a write of each scaled
// pixel that lands in the frame, since the store has a single read-modify-write port.
module scaled_glyph_text_renderer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [7:0]  char_code,
  input  logic [7:0]  char_index,
  input  logic signed [11:0] x_pos,
  input  logic signed [11:0] y_pos,
  input  logic [3:0]  scale,
  input  logic [13:0] read_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic        done_res
);

  sgtr_pkg::item_t in_item, q_item;
  logic q_valid, q_ready;

  always_comb begin
    in_item.command      = sgtr_pkg::cmd_t'(command);
    in_item.char_code    = char_code;
    in_item.char_index   = char_index;
    in_item.x_pos        = x_pos;
    in_item.y_pos        = y_pos;
    in_item.scale        = scale;
    in_item.read_address = read_address;
  end

  assign done_res = 1'b1;

  sgtr_front u_front (
    .clk(clk), .rst(rst), .valid(in_valid), .ready(in_ready), .in_item(in_item),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  sgtr_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .out_valid(out_valid), .out_ready(out_ready), .read_data(read_data)
  );

endmodule

// ----- sim/sgtr_scoreboard.sv -----
// Checker for the glyph text renderer: shadow frame store, result prediction and compare.
`timescale 1ns / 1ps

module sgtr_scoreboard (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  command,
  input  logic [7:0]  char_code,
  input  logic [7:0]  char_index,
  input  logic signed [11:0] x_pos,
  input  logic signed [11:0] y_pos,
  input  logic [3:0]  scale,
  input  logic [13:0] read_address,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  read_data,
  input  logic        done_res,
  output int          mismatches,
  output int          pending
);

  logic [7:0] shadow_frame [0:sgtr_pkg::StoreBytes-1];
  logic [7:0] glyph_rom [0:255][0:4];
  logic [7:0] read_data_q [$];

  task automatic put_glyph(input logic [7:0] code, input logic [39:0] cols);
    for (int c = 0; c < 5; c++) glyph_rom[code][c] = cols[39 - 8*c -: 8];
  endtask

  initial begin
    for (int i = 0; i < 256; i++)
      for (int c = 0; c < 5; c++) glyph_rom[i][c] = 8'h00;
    put_glyph("A", 40'h7E1111117E); put_glyph("B", 40'h7F49494936);
    put_glyph("C", 40'h3E41414122); put_glyph("D", 40'h7F4141221C);
    put_glyph("E", 40'h7F49494941); put_glyph("F", 40'h7F09090901);
    put_glyph("G", 40'h3E4149493A); put_glyph("H", 40'h7F0808087F);
    put_glyph("I", 40'h00417F4100); put_glyph("K", 40'h7F08142241);
    put_glyph("L", 40'h7F40404040); put_glyph("M", 40'h7F020C027F);
    put_glyph("N", 40'h7F0408107F); put_glyph("O", 40'h3E4141413E);
    put_glyph("P", 40'h7F09090906); put_glyph("R", 40'h7F09192946);
    put_glyph("S", 40'h2649494932); put_glyph("T", 40'h01017F0101);
    put_glyph("U", 40'h3F4040403F); put_glyph("V", 40'h1F2040201F);
    put_glyph("W", 40'h3F4038403F); put_glyph("X", 40'h6314081463);
    put_glyph("Y", 40'h0708700807); put_glyph("Z", 40'h6151494543);
    put_glyph("a", 40'h2054545478); put_glyph("b", 40'h7F48444438);
    put_glyph("c", 40'h3844444428); put_glyph("d", 40'h384444287F);
    put_glyph("e", 40'h3854545418); put_glyph("f", 40'h00087E0902);
    put_glyph("g", 40'h18A4A4A47C); put_glyph("h", 40'h7F08040478);
    put_glyph("i", 40'h00447D4000); put_glyph("k", 40'h7F10284400);
    put_glyph("l", 40'h00417F4000); put_glyph("m", 40'h7C04180478);
    put_glyph("n", 40'h7C08040478); put_glyph("o", 40'h3844444438);
    put_glyph("p", 40'h7C14141408); put_glyph("r", 40'h7C08040408);
    put_glyph("s", 40'h4854545424); put_glyph("t", 40'h043F444020);
    put_glyph("u", 40'h3C4040207C); put_glyph("v", 40'h1C2040201C);
    put_glyph("w", 40'h3C4030403C);
    put_glyph("0", 40'h3E5149453E); put_glyph("1", 40'h00427F4000);
    put_glyph("2", 40'h4261514946); put_glyph("3", 40'h2141454B31);
    put_glyph("4", 40'h1814127F10); put_glyph("5", 40'h2745454539);
    put_glyph("6", 40'h3C4A494930); put_glyph("7", 40'h0171090503);
    put_glyph("8", 40'h3649494936); put_glyph("9", 40'h064949291E);
    put_glyph(":", 40'h0000363600); put_glyph("-", 40'h0808080808);
    put_glyph(".", 40'h0060600000); put_glyph("/", 40'h2010080402);
    put_glyph("!", 40'h00005F0000);
  end

  function automatic void blacken(input int px, input int py);
    int idx;
    if (px < 0 || px >= sgtr_pkg::FrameWidth || py < 0 || py >= sgtr_pkg::FrameHeight)
      return;
    idx = py * sgtr_pkg::RowBytes + px / 8;
    if (idx >= sgtr_pkg::StoreBytes) return;
    shadow_frame[idx][7 - (px % 8)] = 1'b0;
  endfunction

  function automatic void render_glyph(input logic [7:0] code, input logic [7:0] pos,
                                       input int ox, input int oy, input int s);
    int cx;
    cx = ox + int'(pos) * 6 * s;
    for (int c = 0; c < 5; c++)
      for (int r = 0; r < 7; r++)
        if (glyph_rom[code][c][r])
          for (int dy = 0; dy < s; dy++)
            for (int dx = 0; dx < s; dx++)
              blacken(cx + c * s + dx, oy + r * s + dy);
  endfunction

  // Applies one accepted command to the shadow store and returns the byte it reads back (zero otherwise).
  function automatic logic [7:0] apply_command(input sgtr_pkg::cmd_t cmd);
    logic [7:0] data;
    data = 8'h00;
    case (cmd)
      sgtr_pkg::CMD_CLEAR:
        for (int i = 0; i < sgtr_pkg::StoreBytes; i++) shadow_frame[i] = 8'hFF;
      sgtr_pkg::CMD_DRAW:
        render_glyph(char_code, char_index, int'(x_pos), int'(y_pos), int'(scale));
      sgtr_pkg::CMD_READ:
        if (read_address < sgtr_pkg::StoreBytes) data = shadow_frame[read_address];
      default:   data = 8'h00;
    endcase
    return data;
  endfunction

  always @(posedge clk) begin
    logic [7:0] want;
    if (rst) begin
      for (int i = 0; i < sgtr_pkg::StoreBytes; i++) shadow_frame[i] = 8'hFF;
      read_data_q.delete();
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (read_data_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: result transfer with nothing expected", $time);
        end else begin
          want = read_data_q.pop_front();
          if (read_data !== want || done_res !== 1'b1) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: read_data exp %02h got %02h, done_res exp 1 got %b",
                       $time, want, read_data, done_res);
          end
        end
      end
      if (in_valid && in_ready)
        read_data_q.push_back(apply_command(sgtr_pkg::cmd_t'(command)));
    end
    pending = read_data_q.size();
  end

endmodule

// ----- sim/tb_scaled_glyph_text_renderer_top.sv -----
// Testbench top for the glyph text renderer: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_scaled_glyph_text_renderer_top;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, done_res;
  logic [1:0]  command;
  logic [7:0]  char_code, char_index, read_data;
  logic signed [11:0] x_pos, y_pos;
  logic [3:0]  scale;
  logic [13:0] read_address;
  int mismatches, pending;
  int sent_count;
  bit hold_off_req, steady_phase;
  int last_x, last_y;

  scaled_glyph_text_renderer_top i_dut (.*);

  sgtr_scoreboard i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offers one command and holds it until the transfer takes place.
  task automatic send_cmd(input sgtr_pkg::cmd_t cmd, input logic [7:0] code,
                          input logic [7:0] pos, input int x, input int y, input int s,
                          input int addr);
    while (!steady_phase && $urandom_range(0, 99) < 17) @(negedge clk);
    in_valid = 1'b1;
    command = cmd;
    char_code = code;
    char_index = pos;
    x_pos = 12'(x);
    y_pos = 12'(y);
    scale = 4'(s);
    read_address = 14'(addr);
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
    sent_count++;
  endtask

  task automatic send_random;
    int pick, x, y, s, pos, addr;
    logic [7:0] code;
    pick = $urandom_range(0, 99);
    code = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(8'h21, 8'h7A)) : 8'($urandom);
    pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8);
    x = $urandom_range(0, 420) - 20;
    y = $urandom_range(0, 320) - 20;
    s = $urandom_range(1, 3);
    addr = $urandom_range(0, 16383);
    if ($urandom_range(0, 9) == 0) begin
      // Full-range fields, mostly clipped; an in-frame origin keeps scale 6 or less.
      x = $signed(12'($urandom));
      y = $signed(12'($urandom));
      s = $urandom_range(0, 15);
      if (s > 6 && x >= 0 && x < sgtr_pkg::FrameWidth && y >= 0 &&
          y < sgtr_pkg::FrameHeight) s = 0;
    end
    if (pick < 3) send_cmd(sgtr_pkg::CMD_CLEAR, code, 8'(pos), x, y, s, addr);
    else if (pick < 48) begin
      last_x = x + pos * 6 * s;
      last_y = y;
      send_cmd(sgtr_pkg::CMD_DRAW, code, 8'(pos), x, y, s, addr);
    end else if (pick < 93) begin
      if ($urandom_range(0, 9) < 6 && last_y >= -10 && last_y < sgtr_pkg::FrameHeight) begin
        y = last_y + $urandom_range(0, 10);
        x = last_x + $urandom_range(0, 24);
        if (y < 0) y = 0;
        if (y >= sgtr_pkg::FrameHeight) y = sgtr_pkg::FrameHeight - 1;
        if (x < 0) x = 0;
        if (x >= sgtr_pkg::FrameWidth) x = sgtr_pkg::FrameWidth - 1;
        addr = y * sgtr_pkg::RowBytes + x / 8;
      end
      send_cmd(sgtr_pkg::CMD_READ, code, 8'(pos), x, y, s, addr);
    end else send_cmd(sgtr_pkg::CMD_NONE, code, 8'(pos), x, y, s, addr);
  endtask

  // Receiver: random stalls, a quiet stretch, and one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_off_req = 1'b0;
      end
      out_ready = steady_phase || ($urandom_range(0, 99) >= 17);
    end
  end

  // Watchdog on cycles without any transfer.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= 200000) begin
        $display("FAIL scaled_glyph_text_renderer_top");
        $finish;
      end
    end
  end

  initial begin
    in_valid = 1'b0;
    command = sgtr_pkg::CMD_NONE;
    char_code = 8'h00;
    char_index = 8'h00;
    x_pos = 12'sd0;
    y_pos = 12'sd0;
    scale = 4'd0;
    read_address = 14'd0;
    hold_off_req = 1'b0;
    steady_phase = 1'b0;
    sent_count = 0;
    last_x = 0;
    last_y = 0;
    rst = 1'b1;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    send_cmd(sgtr_pkg::CMD_READ, 8'h00, 8'h00, 0, 0, 0, 0);
    send_cmd(sgtr_pkg::CMD_DRAW, "A", 8'd0, 0, 0, 1, 0);
    send_cmd(sgtr_pkg::CMD_READ, 8'hFF, 8'hFF, -1, -1, 15, 0);
    send_cmd(sgtr_pkg::CMD_DRAW, "g", 8'd1, 0, 0, 2, 0);
    send_cmd(sgtr_pkg::CMD_READ, 8'h00, 8'h00, 0, 0, 0, 13 * sgtr_pkg::RowBytes + 1);
    send_cmd(sgtr_pkg::CMD_DRAW, 8'd200, 8'd0, 50, 50, 3, 0);
    send_cmd(sgtr_pkg::CMD_DRAW, "W", 8'd0, 60, 60, 0, 0);
    send_cmd(sgtr_pkg::CMD_DRAW, "8", 8'd0, 380, 285, 9, 0);
    send_cmd(sgtr_pkg::CMD_READ, 8'h00, 8'h00, 0, 0, 0, sgtr_pkg::StoreBytes - 1);
    send_cmd(sgtr_pkg::CMD_DRAW, "I", 8'd255, -2048, -2048, 15, 0);
    send_cmd(sgtr_pkg::CMD_DRAW, "M", 8'd0, -3, -4, 2, 0);
    send_cmd(sgtr_pkg::CMD_DRAW, "!", 8'd0, 2047, 2047, 15, 0);
    send_cmd(sgtr_pkg::CMD_DRAW, "0", 8'd0, 396, 100, 1, 0);
    send_cmd(sgtr_pkg::CMD_READ, 8'h00, 8'h00, 0, 0, 0, 100 * sgtr_pkg::RowBytes + 49);
    send_cmd(sgtr_pkg::CMD_READ, 8'h00, 8'h00, 0, 0, 0, sgtr_pkg::StoreBytes);
    send_cmd(sgtr_pkg::CMD_READ, 8'hFF, 8'hFF, 0, 0, 0, 16383);
    send_cmd(sgtr_pkg::CMD_NONE, 8'hFF, 8'hFF, 2047, -2048, 15, 16383);
    send_cmd(sgtr_pkg::CMD_READ, 8'h00, 8'h00, 0, 0, 0, 0);
    send_cmd(sgtr_pkg::CMD_CLEAR, 8'h00, 8'h00, 0, 0, 0, 0);
    send_cmd(sgtr_pkg::CMD_READ, 8'h00, 8'h00, 0, 0, 0, 0);

    for (int n = 0; n < 400; n++) begin
      steady_phase = (n >= 150 && n < 230);
      if (n == 100) hold_off_req = 1'b1;
      if (n == 300) wait (pending == 0);
      send_random();
    end
    steady_phase = 1'b0;

    wait (pending == 0);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS scaled_glyph_text_renderer_top");
    end else begin
      $display("FAIL scaled_glyph_text_renderer_top");
    end
    $finish;
  end

endmodule
